FILE: rtl/srle_pkg.sv
package srle_pkg;

	// A restored byte with this bit set is a run marker.
	localparam logic [7:0] RUN_MARK = 8'h80;
	localparam logic [6:0] COUNT_MASK = 7'h7F;
	// One header byte followed by seven data bytes.
	localparam int GROUP_LEN = 8;
	localparam int POS_W = $clog2(GROUP_LEN);

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       start_of_payload;
		logic       last_of_payload;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [6:0] run_length;
		logic       end_of_payload;
		logic       truncated;
	} result_t;

endpackage

FILE: rtl/srle_input_stage.sv
module srle_input_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  srle_pkg::item_t    in_item,
	input  logic               take,
	output logic               valid_s1,
	output srle_pkg::item_t    item_s1
);

	// The stage refills in the same cycle that its word moves on.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/srle_decode.sv
module srle_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  srle_pkg::item_t     item,
	input  logic                fire,
	output logic                has_result,
	output srle_pkg::result_t   result
);

	logic [7:0]                    msb_q;
	logic [srle_pkg::POS_W-1:0]    pos_q;
	logic                          await_q;
	logic [6:0]                    count_q;

	logic [7:0]                    msb_cur;
	logic [srle_pkg::POS_W-1:0]    pos_cur;
	logic                          await_cur;
	logic [6:0]                    count_cur;

	logic [7:0]                    msb_n;
	logic [srle_pkg::POS_W-1:0]    pos_n;
	logic                          await_n;
	logic [6:0]                    count_n;

	logic [7:0]                    shifted;
	logic [7:0]                    restored;
	logic [7:0]                    val;
	logic [6:0]                    cnt;
	logic                          emit;

	always_comb begin
		// A start flag clears the group and marker state before the word is used.
		msb_cur   = item.start_of_payload ? 8'h00 : msb_q;
		pos_cur   = item.start_of_payload ? '0 : pos_q;
		await_cur = item.start_of_payload ? 1'b0 : await_q;
		count_cur = item.start_of_payload ? 7'h00 : count_q;

		shifted  = {msb_cur[6:0], 1'b0};
		restored = item.payload_byte | (shifted & srle_pkg::RUN_MARK);

		msb_n   = msb_cur;
		pos_n   = pos_cur;
		await_n = await_cur;
		count_n = count_cur;
		val     = 8'h00;
		cnt     = 7'h00;
		emit    = 1'b0;

		if (pos_cur == '0) begin
			msb_n = item.payload_byte;
			pos_n = srle_pkg::POS_W'(1);
		end else begin
			msb_n = shifted;
			pos_n = pos_cur + srle_pkg::POS_W'(1);
			if (await_cur) begin
				await_n = 1'b0;
				val     = restored;
				cnt     = count_cur;
				emit    = (count_cur != 7'h00);
			end else if ((restored & srle_pkg::RUN_MARK) != 8'h00) begin
				await_n = 1'b1;
				count_n = restored[6:0] & srle_pkg::COUNT_MASK;
			end else begin
				val  = restored;
				cnt  = 7'h01;
				emit = 1'b1;
			end
		end

		has_result = item_valid && (emit || item.last_of_payload);

		result.out_byte       = emit ? val : 8'h00;
		result.run_length     = emit ? cnt : 7'h00;
		result.end_of_payload = item.last_of_payload;
		result.truncated      = item.last_of_payload && await_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_q   <= 8'h00;
			pos_q   <= '0;
			await_q <= 1'b0;
			count_q <= 7'h00;
		end else if (fire) begin
			msb_q   <= msb_n;
			pos_q   <= pos_n;
			await_q <= await_n;
			count_q <= count_n;
		end
	end

endmodule

FILE: rtl/srle_output_stage.sv
module srle_output_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  srle_pkg::result_t  result,
	output logic               slot_free,
	output logic               out_valid,
	input  logic               out_ready,
	output srle_pkg::result_t  out_result
);

	logic              valid_q;
	srle_pkg::result_t result_q;

	assign slot_free  = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

FILE: rtl/sysex_7bit_rle_unpacker.sv
// Unpacks the 7-bit packed payload of a system-exclusive message and expands
// run markers into (value, count) words.
// Input channel: in_valid/in_ready carry one raw payload byte per word, with
// start_of_payload to clear the group and marker state and last_of_payload on
// the final byte. Output channel: out_valid/out_ready carry out_byte and
// run_length (1 for a literal), end_of_payload and truncated.
// Header bytes and markers give no word unless they are the last byte; the
// last byte always gives exactly one word.
// An accepted byte is held in the input register, then passes through the
// decode logic into the result register that drives out_valid. A byte can be
// accepted every cycle, so throughput is one byte per cycle as long as the
// receiver keeps out_ready high.
// When the receiver stalls, the result register holds its word, the byte in
// the input register waits only if it would produce a word, and in_ready
// drops once the result register is full and that byte is waiting.
// Reset clears both valid flags and all decode state; no word is in flight
// after reset and the first byte is treated as a group header.
module sysex_7bit_rle_unpacker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] payload_byte,
	input  logic       start_of_payload,
	input  logic       last_of_payload,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [6:0] run_length,
	output logic       end_of_payload,
	output logic       truncated
);

	srle_pkg::item_t   in_item;
	srle_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              has_result;
	logic              slot_free;
	logic              fire;
	srle_pkg::result_t dec_result;
	srle_pkg::result_t out_result;

	assign in_item.payload_byte     = payload_byte;
	assign in_item.start_of_payload = start_of_payload;
	assign in_item.last_of_payload  = last_of_payload;

	// A word that yields no result moves on even while the output is stalled.
	assign fire = valid_s1 && (!has_result || slot_free);

	srle_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srle_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.fire       (fire),
		.has_result (has_result),
		.result     (dec_result)
	);

	srle_output_stage u_output (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && has_result),
		.result     (dec_result),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (out_result)
	);

	assign out_byte       = out_result.out_byte;
	assign run_length     = out_result.run_length;
	assign end_of_payload = out_result.end_of_payload;
	assign truncated      = out_result.truncated;

endmodule
